// File: rtl/pfl_pkg.sv
package pfl_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;

    // page index inside the pool, and link value that also holds the empty marker
    localparam int IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int LINK_W = $clog2(MAX_PAGES + 1);

    localparam int ADDR_W  = 64;
    localparam int BASE_W  = 52;
    localparam int PAGES_W = 11;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(MAX_PAGES);

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REBUILD = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_PAGES = 1'b1;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } free_chk_t;

endpackage

// File: rtl/pfl_link_mem.sv
module pfl_link_mem (
    input  logic                       clk,
    input  logic                       we,
    input  logic [pfl_pkg::IDX_W-1:0]  waddr,
    input  logic [pfl_pkg::LINK_W-1:0] wdata,
    input  logic                       re,
    input  logic [pfl_pkg::IDX_W-1:0]  raddr,
    output logic [pfl_pkg::LINK_W-1:0] rdata
);

    logic [pfl_pkg::LINK_W-1:0] mem [pfl_pkg::MAX_PAGES];
    logic [pfl_pkg::LINK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pfl_free_check.sv
module pfl_free_check (
    input  logic [pfl_pkg::ADDR_W-1:0]  addr,
    input  logic [pfl_pkg::BASE_W-1:0]  base,
    input  logic [pfl_pkg::LINK_W-1:0]  count,
    output pfl_pkg::free_chk_t          chk
);

    logic [pfl_pkg::ADDR_W:0]   diff;
    logic                       aligned;

    // page number minus pool base, with a borrow bit for pages below the pool
    always_comb
    begin
        diff    = {1'b0, pfl_pkg::ADDR_W'(addr >> pfl_pkg::PAGE_SHIFT)}
                  - (pfl_pkg::ADDR_W + 1)'(base);
        aligned = (addr[pfl_pkg::PAGE_SHIFT-1:0] == '0);
        chk.ok  = aligned && !diff[pfl_pkg::ADDR_W]
                  && (diff[pfl_pkg::ADDR_W-1:0] < pfl_pkg::ADDR_W'(count));
        chk.idx = diff[pfl_pkg::IDX_W-1:0];
    end

endmodule

// File: rtl/page_free_list_allocator.sv
// Sequence: free, rebuild of an empty pool and unused actions go from the execute
// state straight to the result state; allocate adds a wait state for the link read;
// a rebuild sweeps its pages, pool_pages clipped to the built capacity, with one
// link-memory write per page, before the result state.
// Throughput: one request at a time; the next request is taken in the cycle its
// predecessor's result is registered.
// Reset: asynchronous, active low; the free list is empty and both registers are 0.
module page_free_list_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [pfl_pkg::BASE_W-1:0]  cfg_data,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pfl_pkg::ACT_W-1:0]   action,
    input  logic [pfl_pkg::ADDR_W-1:0]  page_address,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pfl_pkg::ADDR_W-1:0]  granted_address,
    output logic [pfl_pkg::STAT_W-1:0]  status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ALLOC_WAIT,
        S_SWEEP,
        S_RESP
    } state_t;

    state_t                      state_reg;
    logic [pfl_pkg::BASE_W-1:0]  base_reg;
    logic [pfl_pkg::PAGES_W-1:0] pages_reg;
    logic [pfl_pkg::LINK_W-1:0]  head_reg;
    logic [pfl_pkg::LINK_W-1:0]  sweep_reg;

    // request held while it is worked on
    logic [pfl_pkg::ACT_W-1:0]   act_reg;
    logic [pfl_pkg::ADDR_W-1:0]  addr_reg;

    // result waiting for the output register
    logic [pfl_pkg::ADDR_W-1:0]  res_addr_reg;
    logic [pfl_pkg::STAT_W-1:0]  res_stat_reg;

    // output register
    logic                        out_valid_reg;
    logic [pfl_pkg::ADDR_W-1:0]  out_addr_reg;
    logic [pfl_pkg::STAT_W-1:0]  out_stat_reg;

    logic [pfl_pkg::LINK_W-1:0]  count;
    logic [pfl_pkg::LINK_W-1:0]  sweep_plus;
    logic                        sweep_last;
    logic                        head_empty;
    logic                        slot_free;
    logic [pfl_pkg::ADDR_W-1:0]  grant_calc;
    pfl_pkg::free_chk_t          chk;

    logic                        mem_we;
    logic [pfl_pkg::IDX_W-1:0]   mem_waddr;
    logic [pfl_pkg::LINK_W-1:0]  mem_wdata;
    logic                        mem_re;
    logic [pfl_pkg::LINK_W-1:0]  mem_rdata;

    // Pool size as the hardware sees it: anything above the built capacity is clipped.
    always_comb
    begin
        if (32'(pages_reg) > 32'(pfl_pkg::MAX_PAGES))
        begin
            count = pfl_pkg::EMPTY_MARK;
        end
        else
        begin
            count = pfl_pkg::LINK_W'(pages_reg);
        end
    end

    assign sweep_plus = sweep_reg + pfl_pkg::LINK_W'(1);
    assign sweep_last = (sweep_plus == count);
    assign head_empty = (head_reg >= pfl_pkg::EMPTY_MARK);
    assign slot_free  = !out_valid_reg || out_ready;

    // Byte address of the top page, wrapping at 64 bits.
    assign grant_calc = pfl_pkg::ADDR_W'(
        (pfl_pkg::ADDR_W'(base_reg) + pfl_pkg::ADDR_W'(head_reg)) << pfl_pkg::PAGE_SHIFT);

    // Take a new request when nothing is in flight, or while the previous result
    // moves into the output register.
    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_RESP) && slot_free);

    assign out_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign status          = out_stat_reg;

    pfl_free_check u_free_check (
        .addr  (addr_reg),
        .base  (base_reg),
        .count (count),
        .chk   (chk)
    );

    // Link memory ports:
    //   free    - write the old head into the freed page's link
    //   rebuild - write each page's link to the page above it, last one to the marker
    //   alloc   - read the top page's link, which becomes the new head
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = chk.idx;
        mem_wdata = head_reg;
        mem_re    = 1'b0;
        if (state_reg == S_SWEEP)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg[pfl_pkg::IDX_W-1:0];
            mem_wdata = sweep_last ? pfl_pkg::EMPTY_MARK : sweep_plus;
        end
        else if (state_reg == S_EXEC)
        begin
            mem_we = (act_reg == pfl_pkg::ACT_FREE) && chk.ok;
            mem_re = (act_reg == pfl_pkg::ACT_ALLOC) && !head_empty;
        end
    end

    pfl_link_mem u_link_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (head_reg[pfl_pkg::IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            pages_reg     <= '0;
            head_reg      <= pfl_pkg::EMPTY_MARK;
            sweep_reg     <= '0;
            act_reg       <= pfl_pkg::ACT_ALLOC;
            addr_reg      <= '0;
            res_addr_reg  <= '0;
            res_stat_reg  <= pfl_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            out_addr_reg  <= '0;
            out_stat_reg  <= pfl_pkg::ST_OK;
        end
        else
        begin
            // configuration must be written only while idle; the block itself does not enforce it
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pfl_pkg::CFG_BASE:  base_reg  <= cfg_data;
                    pfl_pkg::CFG_PAGES: pages_reg <= cfg_data[pfl_pkg::PAGES_W-1:0];
                    default:            base_reg  <= base_reg;
                endcase
            end

            // load a finished result, or drop the result once the consumer takes it
            if ((state_reg == S_RESP) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg   <= action;
                        addr_reg  <= page_address;
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    unique case (act_reg)
                        pfl_pkg::ACT_ALLOC:
                        begin
                            if (head_empty)
                            begin
                                res_addr_reg <= '0;
                                res_stat_reg <= pfl_pkg::ST_EMPTY;
                                state_reg    <= S_RESP;
                            end
                            else
                            begin
                                // link read is in flight; pick it up next cycle
                                res_addr_reg <= grant_calc;
                                res_stat_reg <= pfl_pkg::ST_OK;
                                state_reg    <= S_ALLOC_WAIT;
                            end
                        end
                        pfl_pkg::ACT_FREE:
                        begin
                            res_addr_reg <= '0;
                            state_reg    <= S_RESP;
                            if (chk.ok)
                            begin
                                head_reg     <= pfl_pkg::LINK_W'(chk.idx);
                                res_stat_reg <= pfl_pkg::ST_OK;
                            end
                            else
                            begin
                                res_stat_reg <= pfl_pkg::ST_BAD;
                            end
                        end
                        pfl_pkg::ACT_REBUILD:
                        begin
                            res_addr_reg <= '0;
                            res_stat_reg <= pfl_pkg::ST_OK;
                            if (count == '0)
                            begin
                                head_reg  <= pfl_pkg::EMPTY_MARK;
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                sweep_reg <= '0;
                                state_reg <= S_SWEEP;
                            end
                        end
                        default:
                        begin
                            // unused action: answer ok, touch nothing
                            res_addr_reg <= '0;
                            res_stat_reg <= pfl_pkg::ST_OK;
                            state_reg    <= S_RESP;
                        end
                    endcase
                end

                S_ALLOC_WAIT:
                begin
                    head_reg  <= mem_rdata;
                    state_reg <= S_RESP;
                end

                S_SWEEP:
                begin
                    if (sweep_last)
                    begin
                        head_reg  <= '0;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        sweep_reg <= sweep_plus;
                    end
                end

                S_RESP:
                begin
                    if (slot_free)
                    begin
                        out_addr_reg  <= res_addr_reg;
                        out_stat_reg  <= res_stat_reg;
                        if (in_valid)
                        begin
                            act_reg   <= action;
                            addr_reg  <= page_address;
                            state_reg <= S_EXEC;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/pfl_checker.sv
module pfl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pfl_pkg::ADDR_W-1:0]  granted_address,
    input logic [pfl_pkg::STAT_W-1:0]  status
);

    // only the three defined status codes are ever reported
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == pfl_pkg::ST_OK) || (status == pfl_pkg::ST_EMPTY)
                      || (status == pfl_pkg::ST_BAD))
        else $error("undefined status code");

    // a failed request never hands out an address
    a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != pfl_pkg::ST_OK) |-> (granted_address == '0))
        else $error("address granted on a failed request");

    // every granted address is page aligned
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (granted_address[pfl_pkg::PAGE_SHIFT-1:0] == '0))
        else $error("granted address not page aligned");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted_address) && $stable(status))
        else $error("stalled result changed");

endmodule

bind page_free_list_allocator pfl_checker u_pfl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .granted_address (granted_address),
    .status          (status)
);
